// ----- hw/rtl/color_vision_deficiency_sim_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the color vision deficiency simulator.
// Every macro samples on clk_i and is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef COLOR_VISION_DEFICIENCY_SIM_ASSERT_SVH
`define COLOR_VISION_DEFICIENCY_SIM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cvds_pkg.sv -----
// ---------------------------------------------------------------------------
// cvds_pkg
// Types, constants and sRGB tables of the color vision deficiency simulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cvds_pkg;

  // Fixed-point formats.
  localparam int LINEAR_BITS    = 12;
  localparam int COEF_FRAC_BITS = 14;
  localparam int LIN_W          = LINEAR_BITS + 1;
  localparam int COEF_W         = 16;
  localparam int CODE_W         = 8;
  localparam int SEV_W          = 9;
  localparam int NUM_CH         = 3;

  // Arithmetic widths along the datapath.
  localparam int PROD_W   = COEF_W + LIN_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int SCALED_W = LIN_W + COEF_FRAC_BITS;
  localparam int DIFF_W   = ((SUM_W > SCALED_W + 1) ? SUM_W : SCALED_W + 1) + 1;
  localparam int MUL_W    = DIFF_W + SEV_W + 1;
  localparam int BLEND_W  = MUL_W + 1;
  localparam int SHIFT_W  = BLEND_W - COEF_FRAC_BITS - 8;

  // Pipeline depth: all register stages, and the encode search stages among them.
  localparam int NUM_STG  = 11;
  localparam int SRCH_STG = 4;

  localparam logic [LIN_W-1:0]  LIN_ONE  = LIN_W'(1) << LINEAR_BITS;
  localparam logic [SEV_W-1:0]  SEV_FULL = SEV_W'(256);
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 3 * COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEVERITY     = 4'd0,
    REG_PLANE_NORMAL = 4'd1,
    REG_MAT_A_ROW0   = 4'd2,
    REG_MAT_A_ROW1   = 4'd3,
    REG_MAT_A_ROW2   = 4'd4,
    REG_MAT_B_ROW0   = 4'd5,
    REG_MAT_B_ROW1   = 4'd6,
    REG_MAT_B_ROW2   = 4'd7
  } cfg_reg_e;

  // Fields that ride along with a pixel untouched.
  typedef struct packed {
    logic [CODE_W-1:0] alpha;
    logic              last;
  } side_t;

  typedef logic [255:0][LIN_W-1:0] lin_tab_t;

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  // Fifth power of a Q30 value.
  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] a;
    a = (r * r) >> 30;
    a = (a * a) >> 30;
    return (a * r) >> 30;
  endfunction

  // Linear light of the sRGB curve at s = k/510, in linear steps.
  function automatic logic [LIN_W-1:0] decode_half(input int unsigned k);
    logic [63:0] v30;
    logic [63:0] y;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y2;
    logic [63:0] r2;
    if (k <= 20) begin
      v30 = (64'(k) * ONE30 * 64'd100) / 64'd658920;
    end else begin
      y  = ((64'(k) * 64'd1000 + 64'd28050) << 30) / 64'd538050;
      lo = 64'd0;
      hi = ONE30;
      if (y > ONE30) begin
        y = ONE30;
      end
      // Fifth root by bisection.
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q30(mid) <= y) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      y2  = (y * y) >> 30;
      r2  = (lo * lo) >> 30;
      v30 = (y2 * r2) >> 30;
    end
    return LIN_W'((v30 + (64'd1 << (29 - LINEAR_BITS))) >> (30 - LINEAR_BITS));
  endfunction

  function automatic lin_tab_t build_dec_tab();
    lin_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = decode_half(2 * c);
    end
    return t;
  endfunction

  function automatic lin_tab_t build_thr_tab();
    lin_tab_t t;
    t[0] = '0;
    for (int c = 1; c < 256; c++) begin
      t[c] = decode_half(2 * c - 1);
    end
    return t;
  endfunction

  // Decode table and encode thresholds (threshold at the code midpoint).
  localparam lin_tab_t DEC_TAB = build_dec_tab();
  localparam lin_tab_t THR_TAB = build_thr_tab();

endpackage

`default_nettype wire

// ----- hw/rtl/color_vision_deficiency_sim.sv -----
// ---------------------------------------------------------------------------
// color_vision_deficiency_sim
// Dichromacy simulation of a BGRA pixel stream, one pixel per clock while not stalled.
// ---------------------------------------------------------------------------
// Usage: pixels enter on in_valid_i / in_stall_o with blue, green, red,
// alpha and a last-pixel flag; a request is taken when valid is high and
// stall is low. Results leave on out_valid_o / out_stall_i the same way.
// The configuration port writes one register per cycle with cfg_we_i;
// write it only while no pixel is in flight.
// The pipeline takes one pixel every cycle while in_stall_o is low; its depth
// is set by the sRGB decode, the plane product, the matrix products and their
// sum, the severity multiply, the round and clamp, and a four-stage binary
// search for the sRGB code. Each stage moves when it is empty or the stage
// after it moves, so bubbles close up while the receiver stalls; in_stall_o
// rises only when all stages hold a pixel and the output is stalled. A
// stalled result holds steady.
// Reset empties the pipeline, sets severity to full, the plane normal to
// zero and both matrices to the identity.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_vision_deficiency_sim
  import cvds_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration writes.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CODE_W-1:0]     pixel_blue_i,
  input  wire logic [CODE_W-1:0]     pixel_green_i,
  input  wire logic [CODE_W-1:0]     pixel_red_i,
  input  wire logic [CODE_W-1:0]     pixel_alpha_i,
  input  wire logic                  last_pixel_i,
  // Pixel output.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CODE_W-1:0]          out_blue_o,
  output logic [CODE_W-1:0]          out_green_o,
  output logic [CODE_W-1:0]          out_red_o,
  output logic [CODE_W-1:0]          out_alpha_o,
  output logic                       end_of_image_o
);

  // Configuration registers.
  logic [SEV_W-1:0]      sev_q;
  logic [CFG_DATA_W-1:0] normal_q;
  logic [CFG_DATA_W-1:0] mat_a_q [NUM_CH];
  logic [CFG_DATA_W-1:0] mat_b_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sev_q    <= SEV_FULL;
      normal_q <= '0;
      for (int r = 0; r < NUM_CH; r++) begin
        mat_a_q[r] <= CFG_DATA_W'(COEF_ONE) << (COEF_W * r);
        mat_b_q[r] <= CFG_DATA_W'(COEF_ONE) << (COEF_W * r);
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEVERITY:     sev_q      <= cfg_data_i[SEV_W-1:0];
        REG_PLANE_NORMAL: normal_q   <= cfg_data_i;
        REG_MAT_A_ROW0:   mat_a_q[0] <= cfg_data_i;
        REG_MAT_A_ROW1:   mat_a_q[1] <= cfg_data_i;
        REG_MAT_A_ROW2:   mat_a_q[2] <= cfg_data_i;
        REG_MAT_B_ROW0:   mat_b_q[0] <= cfg_data_i;
        REG_MAT_B_ROW1:   mat_b_q[1] <= cfg_data_i;
        REG_MAT_B_ROW2:   mat_b_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] rdy;

  always_comb begin
    rdy[NUM_STG-1] = !vld_q[NUM_STG-1] || !out_stall_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // Alpha and the last flag travel alongside.
  side_t side_q [NUM_STG];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side_q[0] <= '{alpha: pixel_alpha_i, last: last_pixel_i};
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 0: sRGB decode to linear light.
  logic [CODE_W-1:0] pix_code [NUM_CH];
  logic [LIN_W-1:0]  s0_lin_q [NUM_CH];

  assign pix_code[0] = pixel_blue_i;
  assign pix_code[1] = pixel_green_i;
  assign pix_code[2] = pixel_red_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s0_lin_q[c] <= DEC_TAB[pix_code[c]];
      end
    end
  end

  // Stage 1: products of the plane normal with the linear color.
  logic signed [PROD_W-1:0] s1_pn_q  [NUM_CH];
  logic        [LIN_W-1:0]  s1_lin_q [NUM_CH];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s1_pn_q[c]  <= PROD_W'($signed(normal_q[COEF_W*c +: COEF_W]))
                       * $signed(PROD_W'(s0_lin_q[c]));
        s1_lin_q[c] <= s0_lin_q[c];
      end
    end
  end

  // Stage 2: the sign of the plane product selects the matrix.
  logic signed [SUM_W-1:0] pn_sum;
  logic                    s2_use_a_q;
  logic        [LIN_W-1:0] s2_lin_q [NUM_CH];

  assign pn_sum = SUM_W'(s1_pn_q[0]) + SUM_W'(s1_pn_q[1]) + SUM_W'(s1_pn_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_use_a_q <= !pn_sum[SUM_W-1];
      s2_lin_q   <= s1_lin_q;
    end
  end

  // Stage 3: the nine matrix products.
  logic        [CFG_DATA_W-1:0] row_sel [NUM_CH];
  logic signed [PROD_W-1:0]     s3_mp_q [NUM_CH][NUM_CH];
  logic        [LIN_W-1:0]      s3_lin_q [NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      row_sel[r] = s2_use_a_q ? mat_a_q[r] : mat_b_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int r = 0; r < NUM_CH; r++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          s3_mp_q[r][c] <= PROD_W'($signed(row_sel[r][COEF_W*c +: COEF_W]))
                           * $signed(PROD_W'(s2_lin_q[c]));
        end
      end
      s3_lin_q <= s2_lin_q;
    end
  end

  // Stage 4: sum each row into the simulated value.
  logic signed [SUM_W-1:0] s4_sim_q [NUM_CH];
  logic        [LIN_W-1:0] s4_lin_q [NUM_CH];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int r = 0; r < NUM_CH; r++) begin
        s4_sim_q[r] <= SUM_W'(s3_mp_q[r][0]) + SUM_W'(s3_mp_q[r][1])
                       + SUM_W'(s3_mp_q[r][2]);
      end
      s4_lin_q <= s3_lin_q;
    end
  end

  // Stage 5: weight the difference to the original by the severity.
  logic        [SEV_W-1:0]    sev_sat;
  logic signed [DIFF_W-1:0]   diff [NUM_CH];
  logic        [SCALED_W-1:0] scaled [NUM_CH];
  logic signed [MUL_W-1:0]    s5_bp_q [NUM_CH];
  logic        [SCALED_W-1:0] s5_scaled_q [NUM_CH];

  assign sev_sat = (sev_q > SEV_FULL) ? SEV_FULL : sev_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      scaled[c] = SCALED_W'(s4_lin_q[c]) << COEF_FRAC_BITS;
      diff[c]   = DIFF_W'(s4_sim_q[c]) - $signed(DIFF_W'(scaled[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s5_bp_q[c] <= MUL_W'(diff[c]) * $signed(MUL_W'(sev_sat));
      end
      s5_scaled_q <= scaled;
    end
  end

  // Stage 6: round half up, clamp to 0..1 in linear steps.
  logic signed [BLEND_W-1:0] total [NUM_CH];
  logic        [SHIFT_W-1:0] shifted [NUM_CH];
  logic        [LIN_W-1:0]   s6_v_q [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      total[c] = ($signed(BLEND_W'(s5_scaled_q[c])) <<< 8) + BLEND_W'(s5_bp_q[c])
                 + $signed(BLEND_W'(1) << (COEF_FRAC_BITS + 7));
      shifted[c] = SHIFT_W'(total[c] >>> (COEF_FRAC_BITS + 8));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (total[c][BLEND_W-1]) begin
          s6_v_q[c] <= '0;
        end else if (shifted[c] > SHIFT_W'(LIN_ONE)) begin
          s6_v_q[c] <= LIN_ONE;
        end else begin
          s6_v_q[c] <= shifted[c][LIN_W-1:0];
        end
      end
    end
  end

  // Stages 7 to 10: binary search for the largest code whose threshold
  // does not exceed the value, two code bits per stage, MSB first.
  logic [CODE_W-1:0] srch_code_q [SRCH_STG][NUM_CH];
  logic [LIN_W-1:0]  srch_v_q    [SRCH_STG][NUM_CH];

  for (genvar s = 0; s < SRCH_STG; s++) begin : g_srch
    logic [CODE_W-1:0] code_in [NUM_CH];
    logic [LIN_W-1:0]  v_in    [NUM_CH];
    logic [CODE_W-1:0] code_mid [NUM_CH];
    logic [CODE_W-1:0] code_out [NUM_CH];
    logic [CODE_W-1:0] try_hi  [NUM_CH];
    logic [CODE_W-1:0] try_lo  [NUM_CH];

    if (s == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
          code_in[c] = '0;
          v_in[c]    = s6_v_q[c];
        end
      end
    end else begin : g_next
      assign code_in = srch_code_q[s-1];
      assign v_in    = srch_v_q[s-1];
    end

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        try_hi[c]   = code_in[c] | (CODE_W'(1) << (CODE_W - 1 - 2 * s));
        code_mid[c] = (THR_TAB[try_hi[c]] <= v_in[c]) ? try_hi[c] : code_in[c];
        try_lo[c]   = code_mid[c] | (CODE_W'(1) << (CODE_W - 2 - 2 * s));
        code_out[c] = (THR_TAB[try_lo[c]] <= v_in[c]) ? try_lo[c] : code_mid[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[7+s]) begin
        srch_code_q[s] <= code_out;
        srch_v_q[s]    <= v_in;
      end
    end
  end

  // Output register is the last search stage.
  assign out_valid_o    = vld_q[NUM_STG-1];
  assign out_blue_o     = srch_code_q[SRCH_STG-1][0];
  assign out_green_o    = srch_code_q[SRCH_STG-1][1];
  assign out_red_o      = srch_code_q[SRCH_STG-1][2];
  assign out_alpha_o    = side_q[NUM_STG-1].alpha;
  assign end_of_image_o = side_q[NUM_STG-1].last;

  // Assertions.
`include "color_vision_deficiency_sim_assert.svh"

  // Input backpressure only when every stage is occupied.
  `CVDS_ASSERT_IMP(a_stall_full, in_stall_o, &vld_q, "input stalled with a free stage")

  // The encoded blue code brackets its linear value.
  `CVDS_ASSERT_IMP(a_enc_bracket, out_valid_o,
    (THR_TAB[out_blue_o] <= srch_v_q[SRCH_STG-1][0]) &&
    ((out_blue_o == {CODE_W{1'b1}}) ||
     (THR_TAB[CODE_W'(out_blue_o + CODE_W'(1))] > srch_v_q[SRCH_STG-1][0])),
    "encoded code does not match its threshold")

  // A new result only appears after the stage before it held one.
  `CVDS_ASSERT_IMP(a_out_source, $rose(out_valid_o), $past(vld_q[NUM_STG-2]),
    "result appeared without a source")

endmodule

`default_nettype wire
